// ===== hdl/io_expander_shadow_update_controller_macros.svh =====
// Assertion shorthands used by the expander controller (iox_ctrl).
`ifndef IO_EXPANDER_SHADOW_UPDATE_CONTROLLER_MACROS_SVH
`define IO_EXPANDER_SHADOW_UPDATE_CONTROLLER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IOX_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("iox assertion failed");

// Next-cycle implication, checked outside reset.
`define IOX_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("iox assertion failed");

`endif

// ===== hdl/iox_pkg.sv =====
package iox_pkg;

  localparam int unsigned EXPANDERS_DEF = 7;
  localparam int unsigned SETUP_WRITES  = 8;

  localparam logic [6:0]  ACTIVE_RST  = 7'h7F;
  localparam logic [15:0] TIMEOUT_RST = 16'd100;
  localparam logic [6:0]  BASE_RST    = 7'h20;
  localparam logic [7:0]  INIT_A_RST  = 8'h00;
  localparam logic [7:0]  INIT_B_RST  = 8'hFF;

  localparam logic [7:0] REG_OLAT_PAIR = 8'h14;

  typedef enum logic [2:0] {
    CMD_LOAD, CMD_SEND, CMD_SELFCFG, CMD_PROCESS, CMD_SNAPSHOT
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK, ST_BUSY, ST_INVALID, ST_ERROR, ST_NOT_READY
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE, PH_QUEUING, PH_WAITING, PH_READY, PH_FAILED
  } phase_e;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_PROC, S_SETUP, S_WAIT, S_READYCHK, S_RETRYCHK, S_OLAT, S_REPLY
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_LOAD, OP_CFG_START, OP_PRECOUNT, OP_SETUP, OP_WAIT,
    OP_READYCHK, OP_OLAT_BEGIN, OP_OLAT, OP_REPLY
  } op_e;

  typedef enum logic [2:0] {
    REG_ACTIVE_MASK, REG_TIMEOUT, REG_BASE_ADDR, REG_INIT_A, REG_INIT_B
  } reg_e;

  typedef struct packed {
    logic [6:0]  active_mask;
    logic [15:0] timeout_ticks;
    logic [6:0]  base_addr;
    logic [7:0]  init_a;
    logic [7:0]  init_b;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  idx;
    logic        port;
    logic [2:0]  bidx;
    logic        bval;
    logic [31:0] now;
    logic [5:0]  space;
    logic [1:0]  refusal;
    logic        qdone;
    logic [1:0]  tstat;
    logic [1:0]  setup;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [6:0] dev;
    logic [7:0] reg_addr;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
    status_e    st;
    logic       ready;
    logic       last;
  } out_t;

  typedef struct packed {
    op_e     op;
    logic    retry;
    logic    set_st;
    status_e st;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e   cmd;
    logic   idx_valid;
    phase_e phase;
    logic   ready;
    logic   setup_nz;
    logic   space_zero;
    logic   ce_done;
    logic   ce_active;
    logic   walk_done;
    logic   walk_hit;
    logic   pending_nz;
    logic   retry_nz;
    logic   qdone;
    logic   tstat_nz;
    logic   out_free;
  } dp_stat_t;

  // Register written by each set-up step; the last step is the latch pair.
  function automatic logic [7:0] setup_reg(input logic [2:0] k);
    logic [7:0] r;
    case (k)
      3'd0:    r = 8'h0A;
      3'd1:    r = 8'h00;
      3'd2:    r = 8'h02;
      3'd3:    r = 8'h04;
      3'd4:    r = 8'h06;
      3'd5:    r = 8'h08;
      3'd6:    r = 8'h0C;
      default: r = REG_OLAT_PAIR;
    endcase
    return r;
  endfunction

  function automatic status_e refusal_status(input logic [1:0] code);
    status_e s;
    case (code)
      2'd0:    s = ST_BUSY;
      2'd1:    s = ST_INVALID;
      default: s = ST_ERROR;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/iox_regs.sv =====
module iox_regs
  import iox_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_mask   <= ACTIVE_RST;
      cfg_q.timeout_ticks <= TIMEOUT_RST;
      cfg_q.base_addr     <= BASE_RST;
      cfg_q.init_a        <= INIT_A_RST;
      cfg_q.init_b        <= INIT_B_RST;
    end else if (wr) begin
      case (reg_e'(paddr[4:2]))
        REG_ACTIVE_MASK: cfg_q.active_mask   <= pwdata[6:0];
        REG_TIMEOUT:     cfg_q.timeout_ticks <= pwdata[15:0];
        REG_BASE_ADDR:   cfg_q.base_addr     <= pwdata[6:0];
        REG_INIT_A:      cfg_q.init_a        <= pwdata[7:0];
        REG_INIT_B:      cfg_q.init_b        <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[4:2]))
      REG_ACTIVE_MASK: prdata = {25'd0, cfg_q.active_mask};
      REG_TIMEOUT:     prdata = {16'd0, cfg_q.timeout_ticks};
      REG_BASE_ADDR:   prdata = {25'd0, cfg_q.base_addr};
      REG_INIT_A:      prdata = {24'd0, cfg_q.init_a};
      REG_INIT_B:      prdata = {24'd0, cfg_q.init_b};
      default:         prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/iox_dp.sv =====
module iox_dp
  import iox_pkg::*;
#(
  parameter int unsigned EXPANDERS = EXPANDERS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_t      in_i,
  input  cfg_t     cfg_i,
  input  dp_cmd_t  cmd_i,
  output dp_stat_t stat_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_t     out_o
);

  localparam int unsigned IW = (EXPANDERS > 1) ? $clog2(EXPANDERS) : 1;
  localparam int unsigned CW = $clog2(EXPANDERS + 1);
  localparam int unsigned RW = $clog2(EXPANDERS * SETUP_WRITES + 1);
  localparam logic [CW-1:0] EXP_C = CW'(EXPANDERS);

  logic [15:0]          shadow_q    [EXPANDERS];
  logic [15:0]          submitted_q [EXPANDERS];
  logic [EXPANDERS-1:0] dirty_q, pending_q, retry_q;
  phase_e               phase_q;
  logic [CW-1:0]        ce_q, wi_q;
  logic [2:0]           cs_q;
  logic                 ready_q, armed_q, ready_fin_q, retry_mode_q;
  logic                 sel_ce_q, sel_wi_q;
  logic [31:0]          dstart_q;
  logic [5:0]           space_q;
  status_e              st_q;
  in_t                  in_q;
  logic                 out_valid_q;
  out_t                 out_q, out_d;

  logic [7:0]           mask8;
  logic [EXPANDERS-1:0] act, src, wbit;
  logic [3:0]           rd4;
  logic [IW-1:0]        rd_idx, ce_idx, wi_idx;
  logic [15:0]          sh_rd, sub_rd, bit_m, load_v, olat_v;
  logic                 idx_valid, ce_done, ce_active, walk_done, walk_hit;
  logic                 expired, out_free, need_setup, need_olat;
  logic                 emit_setup, emit_olat, emit_reply, snap;
  logic [RW-1:0]        remaining;
  logic [6:0]           dev_ce, dev_wi;
  status_e              ref_st;

  assign mask8  = {1'b0, cfg_i.active_mask};
  assign act    = mask8[EXPANDERS-1:0];
  assign src    = retry_mode_q ? retry_q : dirty_q;

  // One read address for both copies: walk counter, config cursor or target.
  assign rd4    = sel_ce_q ? 4'(ce_q) : (sel_wi_q ? 4'(wi_q) : {1'b0, in_q.idx});
  assign rd_idx = rd4[IW-1:0];
  assign ce_idx = ce_q[IW-1:0];
  assign wi_idx = wi_q[IW-1:0];
  assign sh_rd  = shadow_q[rd_idx];
  assign sub_rd = submitted_q[rd_idx];

  assign idx_valid = {1'b0, in_q.idx} < 4'(EXPANDERS);
  assign ce_done   = ce_q == EXP_C;
  assign ce_active = !ce_done && act[ce_idx];
  assign walk_done = wi_q == EXP_C;
  assign walk_hit  = !walk_done && src[wi_idx] && act[wi_idx];
  assign expired   = armed_q && ((in_q.now - dstart_q) >= {16'd0, cfg_i.timeout_ticks});
  assign out_free  = !out_valid_q || out_ready_i;
  assign ref_st    = refusal_status(in_q.refusal);

  assign bit_m  = 16'd1 << {in_q.port, in_q.bidx};
  assign load_v = in_q.bval ? (sh_rd | bit_m) : (sh_rd & ~bit_m);
  assign olat_v = retry_mode_q ? sub_rd : sh_rd;
  assign dev_ce = cfg_i.base_addr + 7'(ce_q);
  assign dev_wi = cfg_i.base_addr + 7'(wi_q);

  always_comb begin
    wbit         = '0;
    wbit[wi_idx] = 1'b1;
  end

  // Set-up writes still owed, counted from the cursor.
  always_comb begin
    remaining = '0;
    for (int e = 0; e < EXPANDERS; e++) begin
      if (CW'(e) >= ce_q && act[e]) remaining = remaining + RW'(SETUP_WRITES);
    end
    if (ce_active) remaining = remaining - RW'(cs_q);
  end

  assign need_setup = !ce_done && ce_active && space_q != 6'd0;
  assign need_olat  = walk_hit && space_q != 6'd0;
  assign emit_setup = cmd_i.op == OP_SETUP && need_setup;
  assign emit_olat  = cmd_i.op == OP_OLAT && need_olat;
  assign emit_reply = cmd_i.op == OP_REPLY;
  assign snap       = in_q.cmd == CMD_SNAPSHOT && idx_valid;

  always_comb begin
    out_d = '0;
    if (emit_setup) begin
      out_d.dev      = dev_ce;
      out_d.reg_addr = setup_reg(cs_q);
      out_d.b1       = (cs_q == 3'd7) ? sh_rd[7:0] : 8'd0;
      out_d.b2       = (cs_q == 3'd7) ? sh_rd[15:8] : 8'd0;
      out_d.cnt      = (cs_q == 3'd0) ? 2'd2 : 2'd3;
      out_d.st       = ST_OK;
      out_d.ready    = ready_fin_q;
    end else if (emit_olat) begin
      out_d.dev      = dev_wi;
      out_d.reg_addr = REG_OLAT_PAIR;
      out_d.b1       = olat_v[7:0];
      out_d.b2       = olat_v[15:8];
      out_d.cnt      = 2'd3;
      out_d.st       = ST_OK;
      out_d.ready    = ready_q;
    end else begin
      out_d.kind  = 1'b1;
      out_d.dev   = snap ? cfg_i.base_addr + 7'(in_q.idx) : 7'd0;
      out_d.b1    = snap ? sh_rd[7:0] : 8'd0;
      out_d.b2    = snap ? sh_rd[15:8] : 8'd0;
      out_d.st    = st_q;
      out_d.ready = ready_q;
      out_d.last  = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LATCH) in_q <= in_i;
    if (emit_setup || emit_olat || emit_reply) out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int e = 0; e < EXPANDERS; e++) begin
        shadow_q[e]    <= {INIT_B_RST, INIT_A_RST};
        submitted_q[e] <= {INIT_B_RST, INIT_A_RST};
      end
      dirty_q      <= '0;
      pending_q    <= '0;
      retry_q      <= '0;
      phase_q      <= PH_IDLE;
      ce_q         <= '0;
      cs_q         <= '0;
      wi_q         <= '0;
      ready_q      <= 1'b0;
      armed_q      <= 1'b0;
      dstart_q     <= '0;
      ready_fin_q  <= 1'b0;
      retry_mode_q <= 1'b0;
      sel_ce_q     <= 1'b0;
      sel_wi_q     <= 1'b0;
      space_q      <= '0;
      st_q         <= ST_OK;
      out_valid_q  <= 1'b0;
    end else begin
      if (emit_setup || emit_olat || emit_reply) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cmd_i.set_st) st_q <= cmd_i.st;
      case (cmd_i.op)
        OP_LATCH: begin
          space_q  <= in_i.space;
          sel_ce_q <= 1'b0;
          sel_wi_q <= 1'b0;
        end
        OP_LOAD: begin
          shadow_q[rd_idx] <= load_v;
          if (load_v != sh_rd) dirty_q[rd_idx] <= 1'b1;
        end
        OP_CFG_START: begin
          ready_q <= 1'b0;
          if (in_q.setup != 2'd0) begin
            phase_q <= PH_IDLE;
            if (phase_q == PH_FAILED) armed_q <= 1'b0;
            st_q <= status_e'({1'b0, in_q.setup});
          end else begin
            for (int e = 0; e < EXPANDERS; e++) begin
              shadow_q[e]    <= {cfg_i.init_b, cfg_i.init_a};
              submitted_q[e] <= {cfg_i.init_b, cfg_i.init_a};
            end
            dirty_q   <= '0;
            pending_q <= '0;
            retry_q   <= '0;
            armed_q   <= 1'b0;
            ce_q      <= '0;
            cs_q      <= '0;
            phase_q   <= PH_QUEUING;
          end
        end
        OP_PRECOUNT: begin
          // Ready comes up in this beat only if every owed write fits and the queue drains.
          ready_fin_q <= (8'(remaining) <= 8'(space_q)) && in_q.qdone && in_q.tstat == 2'd0;
          sel_ce_q    <= 1'b1;
        end
        OP_SETUP: begin
          if (ce_done) begin
            phase_q <= PH_WAITING;
          end else if (!ce_active) begin
            ce_q <= ce_q + CW'(1);
            cs_q <= '0;
          end else if (space_q == 6'd0) begin
            if (ref_st != ST_BUSY) begin
              st_q    <= ref_st;
              phase_q <= PH_FAILED;
            end else if (expired) begin
              armed_q <= 1'b0;
              phase_q <= PH_FAILED;
              ready_q <= 1'b0;
              st_q    <= ST_ERROR;
            end else begin
              st_q <= ref_st;
            end
          end else begin
            space_q  <= space_q - 6'd1;
            dstart_q <= in_q.now;
            armed_q  <= 1'b1;
            cs_q     <= cs_q + 3'd1;
            if (cs_q == 3'd7) ce_q <= ce_q + CW'(1);
          end
        end
        OP_WAIT: begin
          if (!in_q.qdone) begin
            if (expired) begin
              armed_q <= 1'b0;
              phase_q <= PH_FAILED;
              ready_q <= 1'b0;
              st_q    <= ST_ERROR;
            end else begin
              st_q <= ST_BUSY;
            end
          end else begin
            armed_q <= 1'b0;
            if (in_q.tstat != 2'd0) begin
              phase_q <= PH_FAILED;
              ready_q <= 1'b0;
              st_q    <= status_e'({1'b0, in_q.tstat});
            end else begin
              phase_q <= PH_READY;
              ready_q <= 1'b1;
              st_q    <= ST_OK;
            end
          end
        end
        OP_READYCHK: begin
          if (pending_q != '0) begin
            if (!in_q.qdone) begin
              if (expired) begin
                armed_q   <= 1'b0;
                retry_q   <= retry_q | pending_q;
                pending_q <= '0;
                st_q      <= ST_ERROR;
              end else begin
                st_q <= ST_OK;
              end
            end else begin
              armed_q   <= 1'b0;
              pending_q <= '0;
              if (in_q.tstat != 2'd0) begin
                retry_q <= retry_q | pending_q;
                st_q    <= status_e'({1'b0, in_q.tstat});
              end
            end
          end
        end
        OP_OLAT_BEGIN: begin
          wi_q         <= '0;
          retry_mode_q <= cmd_i.retry;
          sel_wi_q     <= 1'b1;
        end
        OP_OLAT: begin
          if (!walk_hit) begin
            wi_q <= wi_q + CW'(1);
          end else if (space_q == 6'd0) begin
            st_q <= ref_st;
          end else begin
            space_q   <= space_q - 6'd1;
            dstart_q  <= in_q.now;
            armed_q   <= 1'b1;
            retry_q   <= retry_q & ~wbit;
            pending_q <= pending_q | wbit;
            if (!retry_mode_q) begin
              submitted_q[rd_idx] <= sh_rd;
              dirty_q             <= dirty_q & ~wbit;
            end
            wi_q <= wi_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    stat_o            = '0;
    stat_o.cmd        = cmd_e'(in_q.cmd);
    stat_o.idx_valid  = idx_valid;
    stat_o.phase      = phase_q;
    stat_o.ready      = ready_q;
    stat_o.setup_nz   = in_q.setup != 2'd0;
    stat_o.space_zero = space_q == 6'd0;
    stat_o.ce_done    = ce_done;
    stat_o.ce_active  = ce_active;
    stat_o.walk_done  = walk_done;
    stat_o.walk_hit   = walk_hit;
    stat_o.pending_nz = pending_q != '0;
    stat_o.retry_nz   = retry_q != '0;
    stat_o.qdone      = in_q.qdone;
    stat_o.tstat_nz   = in_q.tstat != 2'd0;
    stat_o.out_free   = out_free;
  end

endmodule

// ===== hdl/iox_ctrl.sv =====
`include "io_expander_shadow_update_controller_macros.svh"

module iox_ctrl
  import iox_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat_i.cmd)
          CMD_SEND: state_d = stat_i.ready ? S_OLAT : S_REPLY;
          CMD_SELFCFG: begin
            if (stat_i.phase == PH_READY) state_d = S_REPLY;
            else if (stat_i.phase inside {PH_QUEUING, PH_WAITING}) state_d = S_PROC;
            else state_d = stat_i.setup_nz ? S_REPLY : S_PROC;
          end
          CMD_PROCESS: state_d = S_PROC;
          default:     state_d = S_REPLY;
        endcase
      end
      S_PROC: begin
        case (stat_i.phase)
          PH_QUEUING: state_d = S_SETUP;
          PH_WAITING: state_d = S_WAIT;
          PH_READY:   state_d = S_READYCHK;
          default:    state_d = S_REPLY;
        endcase
      end
      S_SETUP: begin
        if (stat_i.ce_done) state_d = S_WAIT;
        else if (stat_i.ce_active && stat_i.space_zero) state_d = S_REPLY;
      end
      S_WAIT: state_d = S_REPLY;
      S_READYCHK: begin
        if (stat_i.pending_nz && (!stat_i.qdone || stat_i.tstat_nz)) state_d = S_REPLY;
        else state_d = S_RETRYCHK;
      end
      S_RETRYCHK: state_d = stat_i.retry_nz ? S_OLAT : S_REPLY;
      S_OLAT: begin
        if (stat_i.walk_done) state_d = S_REPLY;
        else if (stat_i.walk_hit && stat_i.space_zero) state_d = S_REPLY;
      end
      S_REPLY: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_ready_o    = 1'b0;
    cmd_o        = '0;
    cmd_o.op     = OP_NONE;
    cmd_o.st     = ST_OK;
    case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) cmd_o.op = OP_LATCH;
      end
      S_DISPATCH: begin
        case (stat_i.cmd)
          CMD_LOAD: begin
            cmd_o.op     = stat_i.idx_valid ? OP_LOAD : OP_NONE;
            cmd_o.set_st = 1'b1;
            cmd_o.st     = stat_i.idx_valid ? ST_OK : ST_INVALID;
          end
          CMD_SEND: begin
            if (stat_i.ready) begin
              cmd_o.op = OP_OLAT_BEGIN;
            end else begin
              cmd_o.set_st = 1'b1;
              cmd_o.st     = ST_NOT_READY;
            end
          end
          CMD_SELFCFG: begin
            if (stat_i.phase == PH_READY) begin
              cmd_o.set_st = 1'b1;
            end else if (!(stat_i.phase inside {PH_QUEUING, PH_WAITING})) begin
              cmd_o.op = OP_CFG_START;
            end
          end
          CMD_PROCESS: ;
          CMD_SNAPSHOT: begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = stat_i.idx_valid ? ST_OK : ST_INVALID;
          end
          default: begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_INVALID;
          end
        endcase
      end
      S_PROC: begin
        case (stat_i.phase)
          PH_QUEUING: cmd_o.op = OP_PRECOUNT;
          PH_WAITING, PH_READY: ;
          PH_FAILED: begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_ERROR;
          end
          default: begin
            cmd_o.set_st = 1'b1;
            cmd_o.st     = ST_NOT_READY;
          end
        endcase
      end
      S_SETUP: begin
        // Hold a step that emits until the output register frees up.
        if (stat_i.ce_done || !stat_i.ce_active || stat_i.space_zero || stat_i.out_free)
          cmd_o.op = OP_SETUP;
      end
      S_WAIT:     cmd_o.op = OP_WAIT;
      S_READYCHK: cmd_o.op = OP_READYCHK;
      S_RETRYCHK: begin
        if (stat_i.retry_nz) begin
          cmd_o.op    = OP_OLAT_BEGIN;
          cmd_o.retry = 1'b1;
        end else begin
          cmd_o.set_st = 1'b1;
        end
      end
      S_OLAT: begin
        if (stat_i.walk_done) begin
          cmd_o.set_st = 1'b1;
        end else if (!stat_i.walk_hit || stat_i.space_zero || stat_i.out_free) begin
          cmd_o.op = OP_OLAT;
        end
      end
      S_REPLY: begin
        if (stat_i.out_free) cmd_o.op = OP_REPLY;
      end
      default: ;
    endcase
  end

  `IOX_ASSERT_NEXT(a_accept_dispatch, clk_i, rst_ni, s_valid_i && s_ready_o, state_q == S_DISPATCH)
  `IOX_ASSERT_IMPL(a_reply_free, clk_i, rst_ni, cmd_o.op == OP_REPLY, stat_i.out_free)
  `IOX_ASSERT_IMPL(a_setup_phase, clk_i, rst_ni, state_q == S_SETUP, stat_i.phase == PH_QUEUING)
  `IOX_ASSERT_NEXT(a_reply_idle, clk_i, rst_ni, state_q == S_REPLY && stat_i.out_free, state_q == S_IDLE)

endmodule

// ===== hdl/io_expander_shadow_update_controller.sv =====
// Shadow update controller for a set of two-port bus I/O expanders.
// Input beats on s_axis carry one command (tuser) with its operands and the
// bus queue status sampled for that command (tdata). Each command yields zero
// or more bus write beats (tuser 0) and then exactly one status reply beat
// (tuser 1, tlast 1) on m_axis.
// Sequence: a command is taken into the input register and decoded the next
// cycle; a simple command (bit load, snapshot, unknown code) then has its reply
// written to the output register, and the next beat is taken once the sequencer
// is back in idle. Each walked expander slot or set-up write adds a sequencer
// step before the reply.
// The sequencer handles one command at a time.
// Stall: a stalled m_axis holds the output register and the sequencer waits
// at the next write or reply; nothing is dropped.
// Reset: configuration registers return to defaults, shadows to port A 0x00
// and port B 0xFF, dirty/pending/retry masks clear, expanders unconfigured.
// Configuration sits on the APB port, one register per word address.
module io_expander_shadow_update_controller
  import iox_pkg::*;
#(
  parameter int unsigned EXPANDERS = EXPANDERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // target index, port, bit number, bit level, now_tick, queue_space,
  // refusal_code, queue_done, transfer_status, setup_status, zero pad
  input  logic [55:0] s_axis_tdata,
  // command
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // device_address, target register, first_byte, second_byte, byte_count,
  // status, ready_res, zero pad
  output logic [39:0] m_axis_tdata,
  // kind
  output logic [0:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t     cfg;
  in_t      in_beat;
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  out_t     out_beat;

  // Unpack the input beat.
  always_comb begin
    in_beat.cmd     = s_axis_tuser;
    in_beat.idx     = s_axis_tdata[2:0];
    in_beat.port    = s_axis_tdata[3];
    in_beat.bidx    = s_axis_tdata[6:4];
    in_beat.bval    = s_axis_tdata[7];
    in_beat.now     = s_axis_tdata[39:8];
    in_beat.space   = s_axis_tdata[45:40];
    in_beat.refusal = s_axis_tdata[47:46];
    in_beat.qdone   = s_axis_tdata[48];
    in_beat.tstat   = s_axis_tdata[50:49];
    in_beat.setup   = s_axis_tdata[52:51];
  end

  iox_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  iox_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (dp_stat),
    .cmd_o     (dp_cmd)
  );

  iox_dp #(
    .EXPANDERS (EXPANDERS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_beat),
    .cfg_i       (cfg),
    .cmd_i       (dp_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (out_beat)
  );

  // Pack the result beat, lowest field first.
  assign m_axis_tdata = {3'd0, out_beat.ready, out_beat.st, out_beat.cnt, out_beat.b2,
                         out_beat.b1, out_beat.reg_addr, out_beat.dev};
  assign m_axis_tuser = out_beat.kind;
  assign m_axis_tlast = out_beat.last;

endmodule
